@@ design/aid_pkg.sv @@
package aid_pkg;

   // Field widths.
   localparam int SAMPLE_WIDTH = 16;
   localparam int TIME_WIDTH   = 24;
   localparam int LIMIT_WIDTH  = 8;
   localparam int CNT_WIDTH    = LIMIT_WIDTH + 1;
   localparam int SUB_WIDTH    = 8;

   // Configuration port.
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = SAMPLE_WIDTH;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BAND_CENTER      = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BAND_HALF_WIDTH  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MOTION_LIMIT     = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ABORT_LIMIT      = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STOP_LIMIT       = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SAMPLES_PER_UNIT = 3'd5;

   localparam logic [SUB_WIDTH-1:0] SAMPLES_PER_UNIT_RESET = 8'd10;

   // Classified sample handed from the front to the back.
   typedef struct packed {
      logic motion;
      logic rest;
      logic last;
   } aid_class_type;

   // Debounce and time settings used by the back.
   typedef struct packed {
      logic [LIMIT_WIDTH-1:0] motion_limit;
      logic [LIMIT_WIDTH-1:0] abort_limit;
      logic [LIMIT_WIDTH-1:0] stop_limit;
      logic [SUB_WIDTH-1:0]   samples_per_unit;
   } aid_cfg_type;

   // One closed interval.
   typedef struct packed {
      logic [TIME_WIDTH-1:0] start;
      logic [TIME_WIDTH-1:0] stop;
   } aid_result_type;

   // Status of the back.
   typedef struct packed {
      logic idle;
      logic out_full;
   } aid_status_type;

endpackage

@@ design/aid_front.sv @@
module aid_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic signed [aid_pkg::SAMPLE_WIDTH-1:0] band_center,
   input  logic [aid_pkg::SAMPLE_WIDTH-1:0]       band_half_width,
   input  logic                                  push,
   input  logic signed [aid_pkg::SAMPLE_WIDTH-1:0] sample,
   input  logic                                  last_sample,
   output logic                                  full,
   output logic                                  class_valid,
   output aid_pkg::aid_class_type                class_item,
   input  logic                                  class_take
);
   import aid_pkg::*;

   localparam int BAND_WIDTH = SAMPLE_WIDTH + 2;

   logic signed [BAND_WIDTH-1:0] center_ext;
   logic signed [BAND_WIDTH-1:0] half_ext;
   logic signed [BAND_WIDTH-1:0] band_hi;
   logic signed [BAND_WIDTH-1:0] band_lo;
   logic signed [BAND_WIDTH-1:0] sample_ext;
   aid_class_type                new_item;
   logic                         push_ok;

   aid_class_type entry_ff [2];
   logic          wr_ptr_ff;
   logic          rd_ptr_ff;
   logic [1:0]    count_ff;
   logic [1:0]    count_in;

   // Band edges and the motion or rest decision for the incoming sample.
   always_comb begin
      center_ext = BAND_WIDTH'(band_center);
      half_ext   = BAND_WIDTH'(signed'({1'b0, band_half_width}));
      sample_ext = BAND_WIDTH'(sample);
      band_hi    = center_ext + half_ext;
      band_lo    = center_ext - half_ext;
      new_item.motion = (sample_ext > band_hi) || (sample_ext < band_lo);
      new_item.rest   = (sample_ext < band_hi) && (sample_ext > band_lo);
      new_item.last   = last_sample;
   end

   assign full        = (count_ff == 2'd2);
   assign push_ok     = push && !full;
   assign class_valid = (count_ff != 2'd0);
   assign class_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push_ok && !class_take) begin
         count_in = count_ff + 2'd1;
      end else if (!push_ok && class_take) begin
         count_in = count_ff - 2'd1;
      end
   end

   // Two-entry queue between the classifier and the back.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push_ok) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (class_take) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

@@ design/aid_back.sv @@
module aid_back (
   input  logic                            clock,
   input  logic                            reset,
   input  aid_pkg::aid_cfg_type            cfg,
   input  logic                            class_valid,
   input  aid_pkg::aid_class_type          class_item,
   output logic                            class_take,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [aid_pkg::TIME_WIDTH-1:0]  rsp_interval_start,
   output logic [aid_pkg::TIME_WIDTH-1:0]  rsp_interval_stop,
   output aid_pkg::aid_status_type         status
);
   import aid_pkg::*;

   localparam logic [CNT_WIDTH-1:0]  CNT_MAX  = {CNT_WIDTH{1'b1}};
   localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

   function automatic logic [CNT_WIDTH-1:0] inc_sat(input logic [CNT_WIDTH-1:0] c);
      return (c == CNT_MAX) ? CNT_MAX : c + 1'b1;
   endfunction

   logic                  att_start_ff, att_start_in;
   logic                  att_stop_ff, att_stop_in;
   logic                  started_ff, started_in;
   logic [CNT_WIDTH-1:0]  motion_cnt_ff, motion_cnt_in;
   logic [CNT_WIDTH-1:0]  rest_cnt_ff, rest_cnt_in;
   logic [CNT_WIDTH-1:0]  abort_cnt_ff, abort_cnt_in;
   logic [TIME_WIDTH-1:0] start_mark_ff, start_mark_in;
   logic [TIME_WIDTH-1:0] stop_mark_ff, stop_mark_in;
   logic [TIME_WIDTH-1:0] unit_cnt_ff, unit_cnt_in;
   logic [SUB_WIDTH-1:0]  sub_cnt_ff, sub_cnt_in;

   logic                  emit;
   aid_result_type        result;

   aid_result_type out_ff [2];
   logic           out_wr_ff;
   logic           out_rd_ff;
   logic [1:0]     out_count_ff;
   logic [1:0]     out_count_in;
   logic           out_full;
   logic           out_push;
   logic           out_pop;

   assign out_full   = (out_count_ff == 2'd2);
   assign out_pop    = rsp_pop && (out_count_ff != 2'd0);
   assign class_take = class_valid && (!out_full || rsp_pop);
   assign out_push   = class_take && emit;

   // Debounce state machine for one classified sample.
   always_comb begin
      att_start_in  = att_start_ff;
      att_stop_in   = att_stop_ff;
      started_in    = started_ff;
      motion_cnt_in = motion_cnt_ff;
      rest_cnt_in   = rest_cnt_ff;
      abort_cnt_in  = abort_cnt_ff;
      start_mark_in = start_mark_ff;
      stop_mark_in  = stop_mark_ff;
      unit_cnt_in   = unit_cnt_ff;
      sub_cnt_in    = sub_cnt_ff;
      emit          = 1'b0;
      result.start  = start_mark_ff;
      result.stop   = stop_mark_ff;

      if (class_take) begin
         // Motion cancels a stop attempt and feeds the start attempt.
         if (class_item.motion) begin
            if (att_stop_in) begin
               att_stop_in = 1'b0;
               rest_cnt_in = '0;
            end
            if (started_in) begin
               rest_cnt_in = '0;
            end else if (att_start_in) begin
               motion_cnt_in = inc_sat(motion_cnt_in);
            end else begin
               start_mark_in = unit_cnt_ff;
               att_start_in  = 1'b1;
               motion_cnt_in = inc_sat(motion_cnt_in);
            end
         end

         if (motion_cnt_in > {1'b0, cfg.motion_limit}) begin
            started_in    = 1'b1;
            motion_cnt_in = '0;
         end

         // Rest opens or feeds a stop attempt, or wears down a start attempt.
         if (class_item.rest) begin
            if (started_in && !att_stop_in) begin
               stop_mark_in = unit_cnt_ff;
               att_stop_in  = 1'b1;
               rest_cnt_in  = inc_sat(rest_cnt_in);
            end else if (att_stop_in) begin
               rest_cnt_in = inc_sat(rest_cnt_in);
            end else if (att_start_in) begin
               if (abort_cnt_in > {1'b0, cfg.abort_limit}) begin
                  att_start_in  = 1'b0;
                  motion_cnt_in = '0;
                  abort_cnt_in  = '0;
               end
               abort_cnt_in = inc_sat(abort_cnt_in);
            end
         end

         // Enough rest closes the interval.
         if (rest_cnt_in > {1'b0, cfg.stop_limit}) begin
            emit          = 1'b1;
            result.start  = start_mark_in;
            result.stop   = stop_mark_in;
            motion_cnt_in = '0;
            rest_cnt_in   = '0;
            abort_cnt_in  = '0;
            att_start_in  = 1'b0;
            att_stop_in   = 1'b0;
            started_in    = 1'b0;
         end

         // Time base, saturating at the top of the unit count.
         if (({1'b0, sub_cnt_ff} + 9'd1) >= {1'b0, cfg.samples_per_unit}) begin
            sub_cnt_in = '0;
            if (unit_cnt_ff != TIME_MAX) begin
               unit_cnt_in = unit_cnt_ff + 1'b1;
            end
         end else begin
            sub_cnt_in = sub_cnt_ff + 1'b1;
         end

         // The last sample of a data set clears everything.
         if (class_item.last) begin
            att_start_in  = 1'b0;
            att_stop_in   = 1'b0;
            started_in    = 1'b0;
            motion_cnt_in = '0;
            rest_cnt_in   = '0;
            abort_cnt_in  = '0;
            start_mark_in = '0;
            stop_mark_in  = '0;
            unit_cnt_in   = '0;
            sub_cnt_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         att_start_ff  <= 1'b0;
         att_stop_ff   <= 1'b0;
         started_ff    <= 1'b0;
         motion_cnt_ff <= '0;
         rest_cnt_ff   <= '0;
         abort_cnt_ff  <= '0;
         start_mark_ff <= '0;
         stop_mark_ff  <= '0;
         unit_cnt_ff   <= '0;
         sub_cnt_ff    <= '0;
      end else begin
         att_start_ff  <= att_start_in;
         att_stop_ff   <= att_stop_in;
         started_ff    <= started_in;
         motion_cnt_ff <= motion_cnt_in;
         rest_cnt_ff   <= rest_cnt_in;
         abort_cnt_ff  <= abort_cnt_in;
         start_mark_ff <= start_mark_in;
         stop_mark_ff  <= stop_mark_in;
         unit_cnt_ff   <= unit_cnt_in;
         sub_cnt_ff    <= sub_cnt_in;
      end
   end

   // Two-entry result queue.
   always_comb begin
      out_count_in = out_count_ff;
      if (out_push && !out_pop) begin
         out_count_in = out_count_ff + 2'd1;
      end else if (!out_push && out_pop) begin
         out_count_in = out_count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff    <= 1'b0;
         out_rd_ff    <= 1'b0;
         out_count_ff <= 2'd0;
      end else begin
         out_count_ff <= out_count_in;
         if (out_push) begin
            out_wr_ff <= !out_wr_ff;
         end
         if (out_pop) begin
            out_rd_ff <= !out_rd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         out_ff[out_wr_ff] <= result;
      end
   end

   assign rsp_empty          = (out_count_ff == 2'd0);
   assign rsp_interval_start = out_ff[out_rd_ff].start;
   assign rsp_interval_stop  = out_ff[out_rd_ff].stop;

   assign status.out_full = out_full;
   assign status.idle     = !att_start_ff && !att_stop_ff && !started_ff
                            && (motion_cnt_ff == '0) && (rest_cnt_ff == '0)
                            && (abort_cnt_ff == '0) && (start_mark_ff == '0)
                            && (stop_mark_ff == '0) && (unit_cnt_ff == '0)
                            && (sub_cnt_ff == '0);

endmodule

@@ design/activity_interval_detector_core.sv @@
// Channel   Handshake          Payload
// req       push / full        req_sample, req_last_sample
// rsp       pop / empty        rsp_interval_start, rsp_interval_stop
// csr       csr_write          csr_index, csr_data
//
// One item is taken per cycle unless the back stalls; the debounce update in the back sets that rate.
// A result is written into the result queue at the edge that takes its item; the rsp ports show the queue head.
// Reset is synchronous and clears all state but the queue entries at once; there is no clearing pass.
// The back stalls only when both result slots are full and no pop is pending.
// The front stalls (req_full) when its two-entry queue to the back is full.
module activity_interval_detector_core (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_push,
   output logic                                    req_full,
   input  logic signed [aid_pkg::SAMPLE_WIDTH-1:0] req_sample,
   input  logic                                    req_last_sample,
   output logic                                    rsp_empty,
   input  logic                                    rsp_pop,
   output logic [aid_pkg::TIME_WIDTH-1:0]          rsp_interval_start,
   output logic [aid_pkg::TIME_WIDTH-1:0]          rsp_interval_stop,
   input  logic                                    csr_write,
   input  logic [aid_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [aid_pkg::CSR_DATA_WIDTH-1:0]      csr_data
);
   import aid_pkg::*;

   logic signed [SAMPLE_WIDTH-1:0] band_center_ff;
   logic [SAMPLE_WIDTH-1:0]        band_half_width_ff;
   aid_cfg_type                    cfg_ff;

   logic           class_valid;
   aid_class_type  class_item;
   logic           class_take;
   aid_status_type status;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         band_center_ff          <= '0;
         band_half_width_ff      <= '0;
         cfg_ff.motion_limit     <= '0;
         cfg_ff.abort_limit      <= '0;
         cfg_ff.stop_limit       <= '0;
         cfg_ff.samples_per_unit <= SAMPLES_PER_UNIT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_BAND_CENTER:      band_center_ff <= signed'(csr_data[SAMPLE_WIDTH-1:0]);
            CSR_BAND_HALF_WIDTH:  band_half_width_ff <= csr_data[SAMPLE_WIDTH-1:0];
            CSR_MOTION_LIMIT:     cfg_ff.motion_limit <= csr_data[LIMIT_WIDTH-1:0];
            CSR_ABORT_LIMIT:      cfg_ff.abort_limit <= csr_data[LIMIT_WIDTH-1:0];
            CSR_STOP_LIMIT:       cfg_ff.stop_limit <= csr_data[LIMIT_WIDTH-1:0];
            CSR_SAMPLES_PER_UNIT: cfg_ff.samples_per_unit <= csr_data[SUB_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Front: classify and queue.
   aid_front u_front (
      .clock           (clock),
      .reset           (reset),
      .band_center     (band_center_ff),
      .band_half_width (band_half_width_ff),
      .push            (req_push),
      .sample          (req_sample),
      .last_sample     (req_last_sample),
      .full            (req_full),
      .class_valid     (class_valid),
      .class_item      (class_item),
      .class_take      (class_take)
   );

   // Back: debounce, time base and result queue.
   aid_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .class_valid        (class_valid),
      .class_item         (class_item),
      .class_take         (class_take),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_interval_start (rsp_interval_start),
      .rsp_interval_stop  (rsp_interval_stop),
      .status             (status)
   );

   // The back holds a waiting item only when the result queue blocks it.
   a_back_stall_cause: assert property (@(posedge clock) disable iff (reset)
      (class_valid && !class_take) |-> (status.out_full && !rsp_pop))
      else $error("back stalled with room for a result");

   // An accepted item is queued for the back in the next cycle.
   a_front_queued: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full) |=> class_valid)
      else $error("accepted item missing from the front queue");

   // The last sample of a data set leaves the back fully cleared.
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (class_take && class_item.last) |=> status.idle)
      else $error("state not cleared after the last sample");

endmodule
